FILE: design/sli_pkg.sv
// Package for sorted_list_insert_merge: widths, command and status codes,
// transaction structs and the control struct that drives a list chain.
// No dependencies.
package sli_pkg;

  localparam int LIST_DEPTH  = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  localparam logic [1:0] CMD_INS_A = 2'd0;
  localparam logic [1:0] CMD_INS_B = 2'd1;
  localparam logic [1:0] CMD_MERGE = 2'd2;

  localparam logic [1:0] STS_INSERTED = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_MERGED   = 2'd2;
  localparam logic [1:0] STS_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    val_t       value;
  } in_data_t;

  typedef struct packed {
    logic [1:0] status;
    val_t       item;
    logic       last;
  } out_data_t;

  // per-cycle operation on one list chain
  typedef struct packed {
    logic ins;  // insert new value in sorted place
    logic pop;  // shift toward the head, dropping cell 0
  } chain_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_MERGE
  } state_t;

endpackage

FILE: design/sli_cell.sv
// One cell of a sorted list chain: holds one value, compares it with the
// incoming value and takes the new value or a neighbor's. Uses sli_pkg.
module sli_cell (
  input  logic               clk,
  input  sli_pkg::chain_ctl_t ctl,
  input  logic               occ,       // cell holds a live value
  input  logic               at_end,    // first free cell
  input  logic               prev_gt,   // left neighbor is greater than new value
  input  sli_pkg::val_t      prev_val,
  input  sli_pkg::val_t      next_val,
  input  sli_pkg::val_t      new_val,
  output sli_pkg::val_t      val,
  output logic               gt
);
  import sli_pkg::*;

  val_t val_r;
  val_t val_nxt;

  assign gt  = occ && (val_r > new_val);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (prev_gt) begin
        val_nxt = prev_val;
      end else if (gt || at_end) begin
        val_nxt = new_val;
      end
    end else if (ctl.pop) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: design/sli_chain.sv
// One sorted list: a row of sli_cell instances plus the fill count.
// Uses sli_pkg and sli_cell.
module sli_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  sli_pkg::chain_ctl_t ctl,
  input  sli_pkg::val_t      new_val,
  output sli_pkg::cnt_t      count,
  output sli_pkg::val_t      head
);
  import sli_pkg::*;

  cnt_t count_r;
  cnt_t count_nxt;
  val_t val_w [LIST_DEPTH];
  logic gt_w  [LIST_DEPTH];

  genvar i;
  generate
    for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic occ;
      logic at_end;
      logic prev_gt;
      val_t prev_val;
      val_t next_val;

      assign occ    = cnt_t'(i) < count_r;
      assign at_end = cnt_t'(i) == count_r;

      if (i == 0) begin : g_first
        assign prev_gt  = 1'b0;
        assign prev_val = new_val;
      end else begin : g_mid
        assign prev_gt  = gt_w[i-1];
        assign prev_val = val_w[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_tail
        assign next_val = val_w[i];
      end else begin : g_body
        assign next_val = val_w[i+1];
      end

      sli_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .occ      (occ),
        .at_end   (at_end),
        .prev_gt  (prev_gt),
        .prev_val (prev_val),
        .next_val (next_val),
        .new_val  (new_val),
        .val      (val_w[i]),
        .gt       (gt_w[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;
  assign head  = val_w[0];

endmodule

FILE: design/sorted_list_insert_merge.sv
// Top level of sorted_list_insert_merge: two sorted chains (A, B), the
// command/merge controller and the result register. Uses sli_pkg, sli_chain.
//
//   channel | ports                          | payload
//   --------+--------------------------------+------------------------------
//   input   | in_valid, in_ready, in_data    | in_data_t: command, value
//   result  | out_valid, out_ready, out_data | out_data_t: status, item, last
//
// An insert compares every list cell against the new value in parallel and
// shifts the chain right past the insertion point.
// A merge enters the merge state, then one result per cycle is taken from the
// two chain heads when the result slot can load (chains shift left on pop).
// Reset (rst_n low, synchronous) clears both counts and the controller; cell
// contents are not reset. A stalled result register holds the chains still.
module sorted_list_insert_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sli_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sli_pkg::out_data_t out_data
);
  import sli_pkg::*;

  state_t     state_r;
  state_t     state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_data_t  out_data_r;
  out_data_t  out_data_nxt;

  chain_ctl_t ctl_a;
  chain_ctl_t ctl_b;
  cnt_t       cnt_a;
  cnt_t       cnt_b;
  val_t       head_a;
  val_t       head_b;

  logic       can_load;
  logic       in_acc;
  logic       take_a;
  logic [CNT_W:0] remain;

  sli_chain u_chain_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_a),
    .new_val (in_data.value),
    .count   (cnt_a),
    .head    (head_a)
  );

  sli_chain u_chain_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_b),
    .new_val (in_data.value),
    .count   (cnt_b),
    .head    (head_b)
  );

  // result slot is free or being emptied this cycle
  assign can_load = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && can_load;
  assign in_acc   = in_valid && in_ready;
  assign remain   = {1'b0, cnt_a} + {1'b0, cnt_b};
  // ties go to A
  assign take_a   = (cnt_a != '0) && ((cnt_b == '0) || (head_a <= head_b));

  always_comb begin
    state_nxt     = state_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl_a         = '0;
    ctl_b         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.command)
            CMD_INS_A: begin
              ctl_a.ins     = (cnt_a != cnt_t'(LIST_DEPTH));
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{status: ctl_a.ins ? STS_INSERTED : STS_FULL,
                                item: '0, last: 1'b1};
            end
            CMD_INS_B: begin
              ctl_b.ins     = (cnt_b != cnt_t'(LIST_DEPTH));
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{status: ctl_b.ins ? STS_INSERTED : STS_FULL,
                                item: '0, last: 1'b1};
            end
            CMD_MERGE: begin
              if (remain == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: STS_EMPTY, item: '0, last: 1'b1};
              end else begin
                state_nxt = S_MERGE;
              end
            end
            default: begin
              // unused command: dropped without a result
            end
          endcase
        end
      end
      S_MERGE: begin
        if (can_load) begin
          ctl_a.pop     = take_a;
          ctl_b.pop     = !take_a;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: STS_MERGED,
                            item: take_a ? head_a : head_b,
                            last: (remain == (CNT_W+1)'(1))};
          if (remain == (CNT_W+1)'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // merge in progress always has something left to emit
  a_merge_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> (remain != '0))
    else $error("merge running with both lists empty");

  // final merged transaction leaves both lists empty
  a_merge_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STS_MERGED && out_data.last)
      |-> (cnt_a == '0 && cnt_b == '0))
    else $error("lists not empty after last merged element");

  // insert into a full list A reports full on the next cycle
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.command == CMD_INS_A && cnt_a == cnt_t'(LIST_DEPTH))
      |=> (out_valid && out_data.status == STS_FULL && cnt_a == cnt_t'(LIST_DEPTH)))
    else $error("full list A not reported");

  // merged stream comes out in ascending order
  a_merge_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE && can_load && out_valid_r
      && out_data_r.status == STS_MERGED)
      |-> ((take_a ? head_a : head_b) >= out_data_r.item))
    else $error("merged stream out of order");

endmodule

FILE: sim/tb_sorted_list_insert_merge.sv
// Testbench for sorted_list_insert_merge: directed and random insert/merge traffic,
// checked against a cycle-free list predictor. Depends on sli_pkg and the design top.
module tb_sorted_list_insert_merge;
  import sli_pkg::*;

  // The package has no name for the fourth command code; the block must ignore it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  // No transaction on either channel for this long means the block is hung. The worst
  // legal stall is a run of random ready/valid idles, which never gets close.
  localparam int STALL_LIMIT = 2000;
  // Quiet time after the last result, longer than one full 64-element merge.
  localparam int DRAIN_CYCLES = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_data_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_data_t out_data;

  sorted_list_insert_merge u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Percent of cycles in which each side holds off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  in_data_t  cmd_queue[$];        // commands waiting to be driven
  out_data_t pending_results[$];  // predicted results not yet seen

  // Predictor state: index 0 is list A, index 1 is list B (matches command bit 0).
  val_t mirror [2][LIST_DEPTH];
  int   mirror_cnt [2] = '{0, 0};

  int n_accepted = 0;
  int n_results  = 0;
  int n_merges   = 0;
  int n_full     = 0;
  int n_errors   = 0;
  int stall_cycles = 0;

  // Work out what one accepted command produces and advance the list mirror.
  task automatic apply_command(input in_data_t cmd);
    out_data_t r;
    int sel;
    int i;
    int ia;
    int ib;
    int total;
    bit take_a;
    r = '0;
    r.last = 1'b1;
    case (cmd.command)
      CMD_INS_A, CMD_INS_B: begin
        sel = cmd.command[0];
        if (mirror_cnt[sel] >= LIST_DEPTH) begin
          r.status = STS_FULL;
          n_full++;
        end else begin
          // stable insert: walk back only past strictly greater values
          i = mirror_cnt[sel];
          while (i > 0 && mirror[sel][i-1] > cmd.value) begin
            mirror[sel][i] = mirror[sel][i-1];
            i--;
          end
          mirror[sel][i] = cmd.value;
          mirror_cnt[sel]++;
          r.status = STS_INSERTED;
        end
        pending_results.push_back(r);
      end
      CMD_MERGE: begin
        n_merges++;
        total = mirror_cnt[0] + mirror_cnt[1];
        if (total == 0) begin
          r.status = STS_EMPTY;
          pending_results.push_back(r);
        end else begin
          ia = 0;
          ib = 0;
          for (int k = 0; k < total; k++) begin
            // ties go to list A
            take_a = (ia < mirror_cnt[0]) &&
                     (ib >= mirror_cnt[1] || mirror[0][ia] <= mirror[1][ib]);
            r.status = STS_MERGED;
            r.item   = take_a ? mirror[0][ia] : mirror[1][ib];
            r.last   = (k == total - 1);
            if (take_a) ia++;
            else ib++;
            pending_results.push_back(r);
          end
          mirror_cnt[0] = 0;
          mirror_cnt[1] = 0;
        end
      end
      default: ;  // unused code: no state change, no result
    endcase
  endtask

  // Input driver. Valid holds with its payload until accepted; a new command is
  // loaded in the same step as the acceptance, so back-to-back transactions have
  // no gap unless the random hold-off picks one.
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      apply_command(in_data);
      n_accepted++;
    end
    if (!in_valid || in_ready) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= cmd_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result checker and random back-pressure.
  out_data_t want;
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d item %0d last %0b", $time,
                 out_data.status, out_data.item, out_data.last);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time,
                   want.status, out_data.status);
          n_errors++;
        end
        if (out_data.item !== want.item) begin
          $display("%0t: item mismatch, expected %0d actual %0d", $time,
                   want.item, out_data.item);
          n_errors++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch, expected %0b actual %0b", $time,
                   want.last, out_data.last);
          n_errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, pending_results.size());
      $display("tb_sorted_list_insert_merge: done, errors");
      $finish;
    end
  end

  // Queue one command for the driver.
  task automatic send_item(input logic [1:0] command, input val_t value);
    in_data_t d;
    d.command = command;
    d.value   = value;
    cmd_queue.push_back(d);
  endtask

  // Block until every queued command is in and every predicted result is out.
  task automatic wait_idle();
    while (cmd_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  // Mix of narrow values (lots of ties), the two extremes and full-range noise.
  function automatic val_t rand_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return val_t'($urandom_range(8)) - val_t'(4);
      4:          return VAL_MIN;
      5:          return VAL_MAX;
      default:    return val_t'($urandom);
    endcase
  endfunction

  // Merge with nothing stored: single empty-status transaction.
  task automatic test_empty_merge();
    send_item(CMD_MERGE, '0);
  endtask

  // Extremes in both lists plus equal values across lists, then one merge.
  task automatic test_extremes_and_ties();
    send_item(CMD_INS_A, VAL_MAX);
    send_item(CMD_INS_A, VAL_MIN);
    send_item(CMD_INS_A, val_t'(0));
    send_item(CMD_INS_A, val_t'(-1));
    send_item(CMD_INS_A, val_t'(7));
    send_item(CMD_INS_A, val_t'(7));
    send_item(CMD_INS_B, val_t'(7));
    send_item(CMD_INS_B, VAL_MIN);
    send_item(CMD_INS_B, VAL_MAX);
    send_item(CMD_INS_B, val_t'(-1));
    send_item(CMD_INS_B, val_t'(1));
    send_item(CMD_MERGE, VAL_MAX);
  endtask

  // Only B holds data, then only A.
  task automatic test_one_sided_merge();
    send_item(CMD_INS_B, val_t'(3));
    send_item(CMD_INS_B, val_t'(-3));
    send_item(CMD_INS_B, val_t'(3));
    send_item(CMD_MERGE, '0);
    send_item(CMD_INS_A, val_t'(32'h4000_0000));
    send_item(CMD_INS_A, val_t'(-5));
    send_item(CMD_MERGE, '1);
  endtask

  // Code 3 must leave the lists untouched; the merge after it proves they are empty.
  task automatic test_unused_command();
    send_item(CMD_UNUSED, '1);
    send_item(CMD_UNUSED, '0);
    send_item(CMD_MERGE, '0);
  endtask

  // Overfill both lists, then drain them in one 64-element merge.
  task automatic test_list_full();
    for (int i = 0; i < LIST_DEPTH + 2; i++) send_item(CMD_INS_A, rand_value());
    for (int i = 0; i < LIST_DEPTH + 3; i++) send_item(CMD_INS_B, rand_value());
    send_item(CMD_MERGE, rand_value());
  endtask

  // Rounds of inserts closed by a merge. Each round leans toward one list, and
  // a few long rounds push a list past full. Unused codes are sprinkled in as noise
  // and do not count toward the item budget.
  task automatic test_random_mix(input int n_items);
    int issued;
    int round_len;
    int unsigned bias;
    issued = 0;
    while (issued < n_items) begin
      round_len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 10);
      bias = $urandom_range(100);
      for (int i = 0; i < round_len; i++) begin
        if ($urandom_range(19) == 0) begin
          send_item(CMD_UNUSED, val_t'($urandom));
        end else begin
          send_item(($urandom_range(99) < bias) ? CMD_INS_A : CMD_INS_B, rand_value());
          issued++;
        end
      end
      send_item(CMD_MERGE, val_t'($urandom));
      issued++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // slow receiver, mostly eager sender
    send_idle_pct = 18;
    recv_idle_pct = 71;
    test_empty_merge();
    test_extremes_and_ties();
    test_one_sided_merge();
    test_unused_command();
    test_list_full();
    test_random_mix(70);
    wait_idle();

    // sender starved, receiver mostly ready
    send_idle_pct = 71;
    recv_idle_pct = 18;
    test_random_mix(80);
    wait_idle();

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(80);
    wait_idle();

    // anything arriving now is a stray result and fails in the checker
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input transactions (%0d merges, %0d dropped on full list),",
             n_accepted, n_merges, n_full);
    $display("%0d results checked under three idle patterns.", n_results);
    if (n_errors == 0) begin
      $display("tb_sorted_list_insert_merge: done, clean");
    end else begin
      $display("tb_sorted_list_insert_merge: done, errors");
    end
    $finish;
  end

endmodule
